/* rtl/xfrc_pkg.sv */
// Shared types and constants for the XOR frame receiver checker.
`default_nettype none
package xfrc_pkg;

	localparam int unsigned LEN_W      = 7;
	localparam int unsigned POS_W      = 6;
	localparam int unsigned LIMIT_W    = 4;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [LEN_W-1:0]   LEN_RESET    = 7'd10;
	localparam logic [7:0]         START_RESET  = 8'hFA;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 4'd5;
	localparam logic [LEN_W-1:0]   LEN_MIN      = 7'd4;
	localparam logic [LEN_W-1:0]   LEN_MAX      = 7'd64;
	localparam logic [LIMIT_W-1:0] FAIL_SAT     = 4'hF;
	localparam logic [3:0]         NIBBLE_ONES  = 4'hF;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT   = 2'd2;

	typedef enum logic [1:0] {
		ST_EXACT    = 2'd0,
		ST_TOLERANT = 2'd1,
		ST_UNCHECKED = 2'd2,
		ST_BAD      = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]       frame_byte;
		logic [POS_W-1:0] byte_index;
		logic             frame_last;
		status_t          frame_status;
		logic [7:0]       computed_sum;
		logic             checks_disabled;
	} res_t;

endpackage
`default_nettype wire

/* rtl/xfrc_front.sv */
// Front end: config registers, frame hunt/collect state, XOR and checksum judgment.
`default_nettype none
module xfrc_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [xfrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [xfrc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic [7:0]                     rx_byte,
	output xfrc_pkg::res_t                      res,
	output logic                                push
);
	import xfrc_pkg::*;

	logic [LEN_W-1:0]   frame_length_q;
	logic [7:0]         start_marker_q;
	logic [LIMIT_W-1:0] fail_limit_q;

	logic               collecting_q, collecting_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [7:0]         xor_q, xor_d;
	status_t            verdict_q, verdict_d;
	logic [LIMIT_W-1:0] fails_q, fails_d;
	logic               check_off_q, check_off_d;

	logic [LEN_W-1:0]   len;
	logic [LEN_W-1:0]   pos_ext;
	logic [LIMIT_W-1:0] fails_inc;
	logic               accept;
	logic               emit;

	assign accept = in_valid && !in_stall;

	always_comb begin
		if (frame_length_q < LEN_MIN) begin
			len = LEN_MIN;
		end else if (frame_length_q > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = frame_length_q;
		end
	end

	assign pos_ext   = {1'b0, pos_q};
	assign fails_inc = (fails_q == FAIL_SAT) ? fails_q : fails_q + 1'b1;

	always_comb begin
		collecting_d = collecting_q;
		pos_d        = pos_q;
		xor_d        = xor_q;
		verdict_d    = verdict_q;
		fails_d      = fails_q;
		check_off_d  = check_off_q;
		emit         = 1'b0;
		res.frame_byte   = rx_byte;
		res.byte_index   = pos_q;
		res.frame_last   = 1'b0;
		res.frame_status = ST_EXACT;
		if (!collecting_q) begin
			if (rx_byte == start_marker_q) begin
				emit           = 1'b1;
				collecting_d   = 1'b1;
				pos_d          = POS_W'(1);
				xor_d          = '0;
				verdict_d      = ST_BAD;
				res.byte_index = '0;
			end
		end else begin
			emit = 1'b1;
			if (pos_ext >= len - 7'd1) begin
				// end tag, or a shortened length overtook this frame
				res.frame_last   = 1'b1;
				res.frame_status = verdict_q;
				collecting_d     = 1'b0;
				pos_d            = '0;
			end else begin
				if (pos_ext <= len - 7'd3) begin
					xor_d = xor_q ^ rx_byte;
				end else if (pos_ext == len - 7'd2) begin
					if (check_off_q) begin
						verdict_d = ST_UNCHECKED;
					end else if (xor_q == rx_byte) begin
						verdict_d = ST_EXACT;
						fails_d   = '0;
					end else if (xor_q[7:4] == NIBBLE_ONES && {4'h0, xor_q[3:0]} == rx_byte) begin
						verdict_d = ST_TOLERANT;
						fails_d   = '0;
					end else begin
						fails_d = fails_inc;
						if (fails_inc > fail_limit_q) begin
							check_off_d = 1'b1;
							verdict_d   = ST_UNCHECKED;
						end else begin
							verdict_d = ST_BAD;
						end
					end
				end
				pos_d = pos_q + 1'b1;
			end
		end
		res.computed_sum    = xor_d;
		res.checks_disabled = check_off_d;
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= LEN_RESET;
			start_marker_q <= START_RESET;
			fail_limit_q   <= LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_LENGTH: frame_length_q <= cfg_data[LEN_W-1:0];
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_FAIL_LIMIT:   fail_limit_q   <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			pos_q        <= '0;
			xor_q        <= '0;
			verdict_q    <= ST_EXACT;
			fails_q      <= '0;
			check_off_q  <= 1'b0;
		end else if (accept) begin
			collecting_q <= collecting_d;
			pos_q        <= pos_d;
			xor_q        <= xor_d;
			verdict_q    <= verdict_d;
			fails_q      <= fails_d;
			check_off_q  <= check_off_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/xfrc_queue.sv */
// Small register queue between the front end and the output stage.
`default_nettype none
module xfrc_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire xfrc_pkg::res_t wr_data,
	input  wire logic           pop,
	output xfrc_pkg::res_t      rd_data,
	output logic                full,
	output logic                empty
);
	import xfrc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	res_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/xfrc_back.sv */
// Output stage: registered result beat, refilled from the queue.
`default_nettype none
module xfrc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire xfrc_pkg::res_t q_data,
	output logic                pop,
	input  wire logic           out_stall,
	output logic                out_valid,
	output xfrc_pkg::res_t      out_data
);
	import xfrc_pkg::*;

	logic out_valid_q;
	res_t out_data_q;

	// refill when the register is empty or its beat leaves this cycle
	assign pop       = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= q_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/xor_frame_receiver_checker.sv */
// Top level of the XOR checksum frame receiver.
// Accepts one received byte per cycle with no bubbles: the hunt/collect state, running XOR
// and checksum judgment are computed combinationally in the front end, so in_stall rises only
// when the result queue is full. Each frame byte is written into the queue when accepted and
// then moves on into the output register; hunted-over bytes produce no beat.
// The output register plus QUEUE_DEPTH queue slots absorb stalls on the output side.
// Configuration writes take effect on the next byte and are always ready.
`default_nettype none
module xor_frame_receiver_checker #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [xfrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [xfrc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      rx_byte,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [7:0]                           frame_byte,
	output logic [xfrc_pkg::POS_W-1:0]           byte_index,
	output logic                                 frame_last,
	output logic [1:0]                           frame_status,
	output logic [7:0]                           computed_sum,
	output logic                                 checks_disabled
);
	import xfrc_pkg::*;

	res_t front_res;
	logic push;
	res_t q_data;
	logic q_full;
	logic q_empty;
	logic pop;
	res_t out_data;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	xfrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.res       (front_res),
		.push      (push)
	);

	xfrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_res),
		.pop     (pop),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	xfrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign frame_byte      = out_data.frame_byte;
	assign byte_index      = out_data.byte_index;
	assign frame_last      = out_data.frame_last;
	assign frame_status    = out_data.frame_status;
	assign computed_sum    = out_data.computed_sum;
	assign checks_disabled = out_data.checks_disabled;

endmodule
`default_nettype wire

/* rtl/xfrc_checker.sv */
// Port-level assertions for the frame receiver, bound to the top level.
`default_nettype none
module xfrc_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [7:0]                      frame_byte,
	input  wire logic [xfrc_pkg::POS_W-1:0]      byte_index,
	input  wire logic                            frame_last,
	input  wire logic [1:0]                      frame_status,
	input  wire logic [7:0]                      computed_sum,
	input  wire logic                            checks_disabled
);
	import xfrc_pkg::*;

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(byte_index)
			&& $stable(frame_last) && $stable(frame_status) && $stable(computed_sum))
		else $error("stalled output beat changed");

	// frames are at least four bytes, so the last beat sits at index 3 or above
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> byte_index >= POS_W'(3))
		else $error("frame ended too early");

	a_status_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_last |-> frame_status == ST_EXACT)
		else $error("status set on a non-final beat");

	// start marker beat opens a fresh frame
	a_start_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_index == '0 |-> !frame_last && computed_sum == 8'h00)
		else $error("start beat malformed");

	a_unchecked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last && frame_status == ST_UNCHECKED |-> checks_disabled)
		else $error("unchecked status while checking enabled");

endmodule

bind xor_frame_receiver_checker xfrc_checker u_xfrc_checker (.*);
`default_nettype wire

/* verif/xor_frame_receiver_checker_tb.sv */
// Self-checking testbench for the XOR checksum frame receiver: directed frames, random traffic.
`timescale 1ns / 100ps
module testbench;
	import xfrc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef enum {IDLE_OFF, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum {FR_EXACT, FR_TOLERANT, FR_BAD} frame_kind_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [7:0]            rx_byte   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            frame_byte;
	logic [POS_W-1:0]      byte_index;
	logic                  frame_last;
	logic [1:0]            frame_status;
	logic [7:0]            computed_sum;
	logic                  checks_disabled;

	// shadow of the block: registers and frame state
	logic [LEN_W-1:0]   len_reg    = LEN_RESET;
	logic [7:0]         marker_reg = START_RESET;
	logic [LIMIT_W-1:0] limit_reg  = LIMIT_RESET;
	logic               in_frame   = 1'b0;
	logic [POS_W-1:0]   next_pos   = '0;
	logic [7:0]         run_xor    = '0;
	status_t            pending_verdict = ST_EXACT;
	logic [LIMIT_W-1:0] fail_run   = '0;
	logic               checks_off = 1'b0;

	res_t       frame_beats_due[$];
	int         mismatches    = 0;
	idle_mode_t idle_mode     = IDLE_OFF;
	int         hold_requests = 0;
	int         holds_seen    = 0;
	int         hold_left     = 0;

	xor_frame_receiver_checker u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_byte      (frame_byte),
		.byte_index      (byte_index),
		.frame_last      (frame_last),
		.frame_status    (frame_status),
		.computed_sum    (computed_sum),
		.checks_disabled (checks_disabled)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic bit roll_idle(input bit sender_side);
		case (idle_mode)
			IDLE_SENDER:   return sender_side && ($urandom_range(99) < 68);
			IDLE_RECEIVER: return !sender_side && ($urandom_range(99) < 68);
			IDLE_BOTH:     return $urandom_range(99) < 13;
			default:       return 1'b0;
		endcase
	endfunction

	function automatic int unsigned frame_span();
		if (len_reg < LEN_MIN) return LEN_MIN;
		if (len_reg > LEN_MAX) return LEN_MAX;
		return len_reg;
	endfunction

	task automatic judge_checksum(input logic [7:0] b);
		if (checks_off) begin
			pending_verdict = ST_UNCHECKED;
		end else if (run_xor == b) begin
			pending_verdict = ST_EXACT;
			fail_run = '0;
		end else if (run_xor[7:4] == NIBBLE_ONES && {4'h0, run_xor[3:0]} == b) begin
			pending_verdict = ST_TOLERANT;
			fail_run = '0;
		end else begin
			if (fail_run != FAIL_SAT) fail_run = fail_run + 4'd1;
			// the failure that crosses the limit already reports as unchecked
			if (fail_run > limit_reg) begin
				checks_off = 1'b1;
				pending_verdict = ST_UNCHECKED;
			end else begin
				pending_verdict = ST_BAD;
			end
		end
	endtask

	task automatic predict_beat(input logic [7:0] b);
		int unsigned span;
		int unsigned pos;
		res_t beat;
		span = frame_span();
		beat = '0;
		if (!in_frame) begin
			if (b != marker_reg) return;
			in_frame = 1'b1;
			next_pos = 6'd1;
			run_xor = 8'h00;
			pending_verdict = ST_BAD;
			pos = 0;
		end else begin
			pos = next_pos;
			// a shrunk length can put us past the end: close the frame here
			if (pos >= span - 1) begin
				beat.frame_last = 1'b1;
				beat.frame_status = pending_verdict;
				in_frame = 1'b0;
				next_pos = '0;
			end else begin
				if (pos <= span - 3) run_xor = run_xor ^ b;
				else if (pos == span - 2) judge_checksum(b);
				next_pos = 6'(pos + 1);
			end
		end
		beat.frame_byte = b;
		beat.byte_index = 6'(pos);
		beat.computed_sum = run_xor;
		beat.checks_disabled = checks_off;
		frame_beats_due.push_back(beat);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// output side: compare each beat, then choose the next stall
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frame_beats_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none, actual byte %0d index %0d",
					$time, frame_byte, byte_index);
			end else begin
				want = frame_beats_due.pop_front();
				check_field("frame_byte", want.frame_byte, frame_byte);
				check_field("byte_index", want.byte_index, byte_index);
				check_field("frame_last", want.frame_last, frame_last);
				check_field("frame_status", want.frame_status, frame_status);
				check_field("computed_sum", want.computed_sum, computed_sum);
				check_field("checks_disabled", want.checks_disabled, checks_disabled);
			end
		end
		if (hold_requests != holds_seen) begin
			holds_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= roll_idle(1'b0);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (roll_idle(1'b1)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		predict_beat(b);
	endtask

	// stop offering, wait for every expected beat, then let hunted bytes clear
	task automatic settle();
		in_valid <= 1'b0;
		while (frame_beats_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FRAME_LENGTH: len_reg = data[LEN_W-1:0];
			CFG_START_MARKER: marker_reg = data;
			CFG_FAIL_LIMIT:   limit_reg = data[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// line noise never carries the marker, so frames stay aligned
	task automatic send_noise(input int unsigned count);
		logic [7:0] b;
		repeat (count) begin
			b = 8'($urandom_range(255));
			if (b == marker_reg) b = ~b;
			send_byte(b);
		end
	endtask

	task automatic send_frame(input frame_kind_t kind);
		int unsigned span;
		logic [7:0] sum;
		logic [7:0] b;
		span = frame_span();
		sum = 8'h00;
		send_byte(marker_reg);
		for (int unsigned i = 1; i <= span - 3; i++) begin
			b = 8'($urandom_range(255));
			// force the upper nibble of the sum to all ones
			if (i == span - 3 && kind == FR_TOLERANT) b[7:4] = sum[7:4] ^ NIBBLE_ONES;
			sum = sum ^ b;
			send_byte(b);
		end
		case (kind)
			FR_EXACT:    b = sum;
			FR_TOLERANT: b = {4'h0, sum[3:0]};
			default: begin
				b = sum ^ 8'($urandom_range(255, 1));
				if (sum[7:4] == NIBBLE_ONES && b == {4'h0, sum[3:0]}) b = sum ^ 8'h80;
			end
		endcase
		send_byte(b);
		send_byte(8'($urandom_range(255)));
	endtask

	task automatic run_traffic(input idle_mode_t mode, input int unsigned goal);
		int unsigned sent;
		int unsigned bad_run;
		int unsigned pick;
		frame_kind_t kind;
		idle_mode = mode;
		sent = 0;
		bad_run = 0;
		while (sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				send_noise($urandom_range(3, 1));
			end else begin
				if (pick < 70) kind = FR_EXACT;
				else if (pick < 85) kind = FR_TOLERANT;
				else kind = FR_BAD;
				if (kind == FR_BAD && bad_run >= 3) kind = FR_EXACT;
				bad_run = (kind == FR_BAD) ? bad_run + 1 : 0;
				send_frame(kind);
				sent += frame_span();
			end
		end
		settle();
	endtask

	task automatic test_reset_defaults();
		idle_mode = IDLE_OFF;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(FR_EXACT);
		send_frame(FR_TOLERANT);
		send_frame(FR_BAD);
		send_frame(FR_EXACT);
	endtask

	task automatic test_length_and_marker();
		idle_mode = IDLE_OFF;
		write_reg(CFG_FRAME_LENGTH, 8'd0);
		write_reg(CFG_START_MARKER, 8'h00);
		send_byte(8'hFF);
		send_frame(FR_EXACT);
		write_reg(CFG_START_MARKER, 8'hFF);
		send_byte(8'h00);
		send_frame(FR_TOLERANT);
		write_reg(CFG_UNUSED, 8'hA5);
		send_frame(FR_BAD);
	endtask

	task automatic test_length_change();
		logic [7:0] sum;
		logic [7:0] b;
		idle_mode = IDLE_OFF;
		// shrink before the checksum byte: frame closes as bad
		write_reg(CFG_FRAME_LENGTH, 8'd10);
		send_byte(marker_reg);
		repeat (5) send_byte(8'($urandom_range(255)));
		write_reg(CFG_FRAME_LENGTH, 8'd6);
		send_byte(8'($urandom_range(255)));
		// grow mid-frame
		write_reg(CFG_FRAME_LENGTH, 8'd5);
		send_byte(marker_reg);
		sum = 8'($urandom_range(255));
		send_byte(sum);
		write_reg(CFG_FRAME_LENGTH, 8'd7);
		repeat (3) begin
			b = 8'($urandom_range(255));
			sum = sum ^ b;
			send_byte(b);
		end
		send_byte(sum);
		send_byte(8'($urandom_range(255)));
		// shrink after the checksum was judged
		write_reg(CFG_FRAME_LENGTH, 8'd9);
		send_byte(marker_reg);
		sum = 8'h00;
		repeat (6) begin
			b = 8'($urandom_range(255));
			sum = sum ^ b;
			send_byte(b);
		end
		send_byte(sum);
		write_reg(CFG_FRAME_LENGTH, 8'd6);
		send_byte(8'($urandom_range(255)));
	endtask

	task automatic test_random_traffic();
		write_reg(CFG_FRAME_LENGTH, 8'd8);
		write_reg(CFG_START_MARKER, 8'h55);
		write_reg(CFG_FAIL_LIMIT, 8'd14);
		run_traffic(IDLE_OFF, 400);
		write_reg(CFG_FRAME_LENGTH, 8'($urandom_range(16, 4)));
		write_reg(CFG_START_MARKER, 8'($urandom_range(255)));
		write_reg(CFG_FAIL_LIMIT, 8'hFF);
		run_traffic(IDLE_SENDER, 400);
		// out-of-range length saturates to the largest frame
		write_reg(CFG_FRAME_LENGTH, 8'h7F);
		write_reg(CFG_START_MARKER, 8'($urandom_range(255)));
		run_traffic(IDLE_RECEIVER, 200);
		// bit 7 of the data is dropped by the 7-bit register
		write_reg(CFG_FRAME_LENGTH, {1'b1, 7'($urandom_range(12, 4))});
		write_reg(CFG_FAIL_LIMIT, 8'd14);
		run_traffic(IDLE_BOTH, 400);
	endtask

	task automatic test_output_backpressure();
		int unsigned sent;
		write_reg(CFG_FRAME_LENGTH, 8'd10);
		idle_mode = IDLE_OFF;
		hold_requests++;
		sent = 0;
		while (sent < 150) begin
			send_frame(($urandom_range(3) == 0) ? FR_TOLERANT : FR_EXACT);
			sent += frame_span();
		end
		settle();
		send_frame(FR_EXACT);
	endtask

	task automatic test_fail_saturation();
		write_reg(CFG_FAIL_LIMIT, 8'd15);
		write_reg(CFG_FRAME_LENGTH, 8'd4);
		idle_mode = IDLE_OFF;
		repeat (17) send_frame(FR_BAD);
		send_frame(FR_EXACT);
	endtask

	task automatic test_checks_disable();
		write_reg(CFG_FAIL_LIMIT, 8'd0);
		idle_mode = IDLE_OFF;
		send_frame(FR_BAD);
		send_frame(FR_TOLERANT);
		write_reg(CFG_FRAME_LENGTH, 8'($urandom_range(12, 4)));
		run_traffic(IDLE_BOTH, 250);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_length_and_marker();
		test_length_change();
		test_random_traffic();
		test_output_backpressure();
		test_fail_saturation();
		test_checks_disable();
		settle();
		repeat (16) @(posedge clk);
		if (frame_beats_due.size() != 0) begin
			mismatches++;
			$display("%0t: %0d beats expected, 0 received", $time, frame_beats_due.size());
		end
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
